### src/ansi_terminal_cell_writer_top_macros.svh
// Assertion macros shared by the checker.
`ifndef ANSI_TERMINAL_CELL_WRITER_TOP_MACROS_SVH
`define ANSI_TERMINAL_CELL_WRITER_TOP_MACROS_SVH
// Implication checked at every edge outside reset.
`define ACW_ASSERT_IMPL(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("acw check failed");
// Implication whose consequent is checked in the next cycle.
`define ACW_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("acw check failed");
`endif

### src/acw_pkg.sv
package acw_pkg;

    localparam int unsigned ROW_LIMIT = 1023;
    localparam int unsigned GLYPH_MAX_BYTES = 4;
    localparam logic [7:0] WIDTH_RESET = 8'd120;
    localparam logic [7:0] CH_ESC = 8'h1b;
    localparam logic [7:0] CH_LBRACKET = 8'h5b;
    localparam logic [7:0] CH_NL = 8'h0a;
    localparam logic [7:0] CH_CR = 8'h0d;
    localparam logic [7:0] CH_SEMI = 8'h3b;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] FINAL_LO = 8'h40;
    localparam logic [7:0] FINAL_HI = 8'h7e;
    localparam logic [7:0] CONT_MASK = 8'hc0;
    localparam logic [7:0] CONT_CODE = 8'h80;
    localparam logic [7:0] FB_A = 8'h41;
    localparam logic [7:0] FB_B = 8'h42;
    localparam logic [7:0] FB_C = 8'h43;
    localparam logic [7:0] FB_D = 8'h44;
    localparam logic [7:0] FB_E = 8'h45;
    localparam logic [7:0] FB_F = 8'h46;
    localparam logic [7:0] FB_G = 8'h47;
    localparam logic [7:0] FB_H = 8'h48;
    localparam logic [7:0] FB_K = 8'h4b;
    localparam logic [7:0] FB_LD = 8'h64;
    localparam logic [7:0] FB_LF = 8'h66;
    localparam logic [7:0] FB_LM = 8'h6d;
    localparam logic [7:0] FB_LS = 8'h73;
    localparam logic [7:0] FB_LU = 8'h75;

    typedef enum logic [1:0] {
        MODE_GROUND,
        MODE_ESC,
        MODE_CSI
    } mode_t;

    // Classified operation handed from the front to the back.
    typedef enum logic [2:0] {
        OP_NONE,
        OP_GLYPH_START,
        OP_GLYPH_CONT,
        OP_FLUSH_ONLY,
        OP_NEWLINE,
        OP_RETURN,
        OP_CSI
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [7:0]  data;
        logic        eof;
        logic [15:0] p0;
        logic [15:0] p1;
        logic [1:0]  seen;
        logic        priv;
        logic [1:0]  blen;
    } cmd_t;

    typedef struct packed {
        logic [9:0]  cell_row;
        logic [7:0]  span_start;
        logic [7:0]  span_end;
        logic [31:0] glyph_bytes;
        logic [2:0]  glyph_length;
        logic        colour_active;
        logic [15:0] colour_first;
        logic [15:0] colour_second;
        logic        last_of_run;
    } result_t;

endpackage

### src/acw_in_if.sv
interface acw_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;
    logic       end_of_frame;

    modport source (output valid, output stream_byte, output end_of_frame, input ready);
    modport sink (input valid, input stream_byte, input end_of_frame, output ready);
endinterface

### src/acw_out_if.sv
interface acw_out_if;
    logic        valid;
    logic        ready;
    logic [9:0]  cell_row;
    logic [7:0]  span_start;
    logic [7:0]  span_end;
    logic [31:0] glyph_bytes;
    logic [2:0]  glyph_length;
    logic        colour_active;
    logic [15:0] colour_first;
    logic [15:0] colour_second;
    logic        last_of_run;

    modport source (output valid, output cell_row, output span_start, output span_end,
        output glyph_bytes, output glyph_length, output colour_active,
        output colour_first, output colour_second, output last_of_run, input ready);
    modport sink (input valid, input cell_row, input span_start, input span_end,
        input glyph_bytes, input glyph_length, input colour_active,
        input colour_first, input colour_second, input last_of_run, output ready);
endinterface

### src/acw_front.sv
module acw_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        in_byte,
    input  logic              in_eof,
    output logic              cmd_valid,
    input  logic              cmd_ready,
    output acw_pkg::cmd_t     cmd
);

    acw_pkg::mode_t mode_reg, mode_next;
    logic [15:0] p0_reg, p0_next, p1_reg, p1_next;
    logic [1:0]  seen_reg, seen_next, blen_reg, blen_next;
    logic        slot_reg, slot_next, priv_reg, priv_next;
    logic        glyph_reg, glyph_next;
    logic [15:0] cur_p;
    logic [19:0] prod;

    assign in_ready = cmd_ready;
    assign cmd_valid = in_valid;
    assign cur_p = slot_reg ? p1_reg : p0_reg;
    assign prod = {cur_p, 3'b000} + {2'b00, cur_p, 1'b0} + {12'd0, in_byte - acw_pkg::CH_ZERO};

    // Parser: classify each byte and build CSI parameters.
    always_comb
    begin
        mode_next = mode_reg;
        p0_next = p0_reg;
        p1_next = p1_reg;
        seen_next = seen_reg;
        blen_next = blen_reg;
        slot_next = slot_reg;
        priv_next = priv_reg;
        glyph_next = glyph_reg;
        cmd = '0;
        cmd.data = in_byte;
        cmd.eof = in_eof;
        cmd.p0 = p0_reg;
        cmd.p1 = p1_reg;
        cmd.seen = seen_reg;
        cmd.priv = priv_reg;
        cmd.blen = blen_reg;
        cmd.op = acw_pkg::OP_NONE;
        unique case (mode_reg)
            acw_pkg::MODE_ESC:
            begin
                if (in_byte == acw_pkg::CH_LBRACKET)
                begin
                    mode_next = acw_pkg::MODE_CSI;
                    p0_next = '0;
                    p1_next = '0;
                    seen_next = '0;
                    slot_next = 1'b0;
                    priv_next = 1'b0;
                    blen_next = '0;
                end
                else
                begin
                    mode_next = acw_pkg::MODE_GROUND;
                end
            end
            acw_pkg::MODE_CSI:
            begin
                if (in_byte >= acw_pkg::FINAL_LO && in_byte <= acw_pkg::FINAL_HI)
                begin
                    mode_next = acw_pkg::MODE_GROUND;
                    cmd.op = acw_pkg::OP_CSI;
                end
                else
                begin
                    if (blen_reg != 2'd3)
                    begin
                        blen_next = blen_reg + 2'd1;
                    end
                    if (in_byte >= acw_pkg::CH_ZERO && in_byte <= acw_pkg::CH_NINE)
                    begin
                        if (slot_reg)
                        begin
                            p1_next = (prod > 20'd65535) ? 16'hffff : prod[15:0];
                            seen_next[1] = 1'b1;
                        end
                        else
                        begin
                            p0_next = (prod > 20'd65535) ? 16'hffff : prod[15:0];
                            seen_next[0] = 1'b1;
                        end
                    end
                    else if (in_byte == acw_pkg::CH_SEMI)
                    begin
                        slot_next = 1'b1;
                    end
                    else
                    begin
                        priv_next = 1'b1;
                    end
                end
            end
            default:
            begin
                if (glyph_reg && (in_byte & acw_pkg::CONT_MASK) == acw_pkg::CONT_CODE)
                begin
                    cmd.op = acw_pkg::OP_GLYPH_CONT;
                end
                else
                begin
                    glyph_next = 1'b0;
                    if (in_byte == acw_pkg::CH_ESC)
                    begin
                        mode_next = acw_pkg::MODE_ESC;
                        cmd.op = acw_pkg::OP_FLUSH_ONLY;
                    end
                    else if (in_byte == acw_pkg::CH_NL)
                    begin
                        cmd.op = acw_pkg::OP_NEWLINE;
                    end
                    else if (in_byte == acw_pkg::CH_CR)
                    begin
                        cmd.op = acw_pkg::OP_RETURN;
                    end
                    else if (in_byte >= acw_pkg::CH_SPACE)
                    begin
                        cmd.op = acw_pkg::OP_GLYPH_START;
                        glyph_next = 1'b1;
                    end
                    else
                    begin
                        cmd.op = acw_pkg::OP_FLUSH_ONLY;
                    end
                end
            end
        endcase
        if (in_eof)
        begin
            mode_next = acw_pkg::MODE_GROUND;
            p0_next = '0;
            p1_next = '0;
            seen_next = '0;
            slot_next = 1'b0;
            priv_next = 1'b0;
            blen_next = '0;
            glyph_next = 1'b0;
        end
    end

    // Parser state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= acw_pkg::MODE_GROUND;
            p0_reg <= '0;
            p1_reg <= '0;
            seen_reg <= '0;
            blen_reg <= '0;
            slot_reg <= 1'b0;
            priv_reg <= 1'b0;
            glyph_reg <= 1'b0;
        end
        else if (in_valid && cmd_ready)
        begin
            mode_reg <= mode_next;
            p0_reg <= p0_next;
            p1_reg <= p1_next;
            seen_reg <= seen_next;
            blen_reg <= blen_next;
            slot_reg <= slot_next;
            priv_reg <= priv_next;
            glyph_reg <= glyph_next;
        end
    end

endmodule

### src/acw_queue.sv
module acw_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_valid,
    output logic          wr_ready,
    input  acw_pkg::cmd_t wr_data,
    output logic          rd_valid,
    input  logic          rd_ready,
    output acw_pkg::cmd_t rd_data
);

    // Two-entry queue; the entries stay in place and are read at the head pointer.
    acw_pkg::cmd_t ent_reg [2];
    logic [1:0]    cnt_reg;
    logic          head_reg, tail_reg;
    logic          push, pop;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data = ent_reg[head_reg];
    assign push = wr_valid && wr_ready;
    assign pop = rd_valid && rd_ready;

    // Storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[tail_reg] <= wr_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            head_reg <= 1'b0;
            tail_reg <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                tail_reg <= ~tail_reg;
            end
            if (pop)
            begin
                head_reg <= ~head_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

### src/acw_back.sv
module acw_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [7:0]        line_width,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  acw_pkg::cmd_t     cmd,
    output logic              res_valid,
    input  logic              res_ready,
    output acw_pkg::result_t  res
);

    logic [9:0]  row_reg, row_next, srow_reg, srow_next, prow_reg, prow_next;
    logic [7:0]  col_reg, col_next, scol_reg, scol_next, pcol_reg, pcol_next;
    logic [32:0] colour_reg, colour_next, pcolour_reg, pcolour_next;
    logic [31:0] gbytes_reg, gbytes_next;
    logic [2:0]  glen_reg, glen_next;
    logic        gvalid_reg, gvalid_next, gwrite_reg, gwrite_next;

    // Output buffer of two result slots.
    acw_pkg::result_t r0_reg, r1_reg, r0_next, r1_next, ra, rb;
    logic [1:0]  rcnt_reg, rcnt_next;
    logic        have_a, have_b;

    logic [7:0]  w, wm1;
    logic [15:0] n1, n2;
    logic [16:0] rsum, csum;
    logic [7:0]  kstart, kend;
    logic [8:0]  kend_raw;
    logic        go;

    assign w = (line_width == 8'd0) ? 8'd1 : line_width;
    assign wm1 = w - 8'd1;
    assign n1 = cmd.seen[0] ? cmd.p0 : 16'd1;
    assign n2 = cmd.seen[1] ? cmd.p1 : 16'd1;
    assign rsum = {7'd0, row_reg} + {1'b0, n1};
    assign csum = {9'd0, col_reg} + {1'b0, n1};

    // Accept only when the buffer is empty or drains this cycle.
    assign cmd_ready = (rcnt_reg == 2'd0) || (rcnt_reg == 2'd1 && res_ready);
    assign go = cmd_valid && cmd_ready;
    assign res_valid = (rcnt_reg != 2'd0);
    assign res = r0_reg;

    function automatic logic [9:0] row_abs(input logic [15:0] n);
        logic [15:0] r;
        r = (n == 16'd0) ? 16'd0 : n - 16'd1;
        return (r > 16'(acw_pkg::ROW_LIMIT)) ? 10'(acw_pkg::ROW_LIMIT) : r[9:0];
    endfunction

    function automatic logic [7:0] col_pos(input logic [15:0] n, input logic [7:0] lim);
        logic [15:0] r;
        r = (n == 16'd0) ? 16'd0 : n - 16'd1;
        return (r > {8'd0, lim}) ? lim : r[7:0];
    endfunction

    function automatic logic [9:0] row_inc(input logic [9:0] r);
        return (r == 10'(acw_pkg::ROW_LIMIT)) ? r : r + 10'd1;
    endfunction

    // Executes one command: cursor, colour, glyph and up to two results.
    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        srow_next = srow_reg;
        scol_next = scol_reg;
        prow_next = prow_reg;
        pcol_next = pcol_reg;
        colour_next = colour_reg;
        pcolour_next = pcolour_reg;
        gbytes_next = gbytes_reg;
        glen_next = glen_reg;
        gvalid_next = gvalid_reg;
        gwrite_next = gwrite_reg;
        have_a = 1'b0;
        have_b = 1'b0;
        ra = '0;
        rb = '0;
        kstart = col_reg;
        kend_raw = {1'b0, w};
        kend = w;
        ra.cell_row = prow_reg;
        ra.span_start = pcol_reg;
        ra.span_end = pcol_reg + 8'd1;
        ra.glyph_bytes = gbytes_reg;
        ra.glyph_length = glen_reg;
        ra.colour_active = pcolour_reg[32];
        ra.colour_second = pcolour_reg[31:16];
        ra.colour_first = pcolour_reg[15:0];
        case (cmd.op)
            acw_pkg::OP_GLYPH_CONT:
            begin
                if (glen_reg < 3'(acw_pkg::GLYPH_MAX_BYTES))
                begin
                    gbytes_next = gbytes_reg | ({24'd0, cmd.data} << {glen_reg[1:0], 3'b000});
                    glen_next = glen_reg + 3'd1;
                end
            end
            acw_pkg::OP_GLYPH_START, acw_pkg::OP_FLUSH_ONLY,
            acw_pkg::OP_NEWLINE, acw_pkg::OP_RETURN:
            begin
                have_a = gvalid_reg && gwrite_reg;
                gvalid_next = 1'b0;
                if (cmd.op == acw_pkg::OP_NEWLINE)
                begin
                    row_next = row_inc(row_reg);
                    col_next = '0;
                end
                else if (cmd.op == acw_pkg::OP_RETURN)
                begin
                    col_next = '0;
                end
                else if (cmd.op == acw_pkg::OP_GLYPH_START)
                begin
                    gvalid_next = 1'b1;
                    gwrite_next = col_reg < w;
                    gbytes_next = {24'd0, cmd.data};
                    glen_next = 3'd1;
                    prow_next = row_reg;
                    pcol_next = col_reg;
                    pcolour_next = colour_reg;
                    if ({1'b0, col_reg} + 9'd1 >= {1'b0, w})
                    begin
                        col_next = '0;
                        row_next = row_inc(row_reg);
                    end
                    else
                    begin
                        col_next = col_reg + 8'd1;
                    end
                end
            end
            acw_pkg::OP_CSI:
            begin
                if (cmd.data == acw_pkg::FB_LM)
                begin
                    if (cmd.blen == 2'd0 ||
                        (cmd.blen == 2'd1 && cmd.seen[0] && cmd.p0 == 16'd0))
                    begin
                        colour_next = '0;
                    end
                    else
                    begin
                        colour_next = {1'b1, cmd.p1, cmd.p0};
                    end
                end
                else if (!cmd.priv)
                begin
                    case (cmd.data)
                        acw_pkg::FB_A:
                            row_next = ({6'd0, row_reg} <= n1) ? 10'd0 : row_reg - n1[9:0];
                        acw_pkg::FB_B:
                            row_next = (rsum > 17'(acw_pkg::ROW_LIMIT)) ?
                                10'(acw_pkg::ROW_LIMIT) : rsum[9:0];
                        acw_pkg::FB_C:
                            col_next = (csum > {9'd0, wm1}) ? wm1 : csum[7:0];
                        acw_pkg::FB_D:
                            col_next = ({8'd0, col_reg} <= n1) ? 8'd0 : col_reg - n1[7:0];
                        acw_pkg::FB_E:
                        begin
                            row_next = (rsum > 17'(acw_pkg::ROW_LIMIT)) ?
                                10'(acw_pkg::ROW_LIMIT) : rsum[9:0];
                            col_next = '0;
                        end
                        acw_pkg::FB_F:
                        begin
                            row_next = ({6'd0, row_reg} <= n1) ? 10'd0 : row_reg - n1[9:0];
                            col_next = '0;
                        end
                        acw_pkg::FB_G:
                            col_next = col_pos(n1, wm1);
                        acw_pkg::FB_LD:
                            row_next = row_abs(n1);
                        acw_pkg::FB_H, acw_pkg::FB_LF:
                        begin
                            row_next = row_abs(n1);
                            col_next = col_pos(n2, wm1);
                        end
                        acw_pkg::FB_LS:
                        begin
                            srow_next = row_reg;
                            scol_next = col_reg;
                        end
                        acw_pkg::FB_LU:
                        begin
                            row_next = srow_reg;
                            col_next = scol_reg;
                        end
                        acw_pkg::FB_K:
                        begin
                            if (cmd.seen[0] && cmd.p0 == 16'd1)
                            begin
                                kstart = '0;
                                kend_raw = {1'b0, col_reg} + 9'd1;
                            end
                            else if (cmd.seen[0] && cmd.p0 == 16'd2)
                            begin
                                kstart = '0;
                            end
                            kend = (kend_raw > {1'b0, w}) ? w : kend_raw[7:0];
                            if (kstart < kend)
                            begin
                                have_a = 1'b1;
                                ra = '0;
                                ra.cell_row = row_reg;
                                ra.span_start = kstart;
                                ra.span_end = kend;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            default:
            begin
            end
        endcase
        // End of frame flushes the glyph then clears state.
        if (cmd.eof)
        begin
            if (gvalid_next && gwrite_next)
            begin
                rb.cell_row = prow_next;
                rb.span_start = pcol_next;
                rb.span_end = pcol_next + 8'd1;
                rb.glyph_bytes = gbytes_next;
                rb.glyph_length = glen_next;
                rb.colour_active = pcolour_next[32];
                rb.colour_second = pcolour_next[31:16];
                rb.colour_first = pcolour_next[15:0];
                have_b = 1'b1;
            end
            row_next = '0;
            col_next = '0;
            srow_next = '0;
            scol_next = '0;
            prow_next = '0;
            pcol_next = '0;
            colour_next = '0;
            pcolour_next = '0;
            gvalid_next = 1'b0;
            gwrite_next = 1'b0;
            gbytes_next = '0;
            glen_next = '0;
        end
        ra.last_of_run = !have_b;
        rb.last_of_run = 1'b1;
        // Output buffer update.
        r0_next = r0_reg;
        r1_next = r1_reg;
        rcnt_next = rcnt_reg;
        if (res_valid && res_ready)
        begin
            r0_next = r1_reg;
            rcnt_next = rcnt_reg - 2'd1;
        end
        if (go)
        begin
            if (have_a && have_b)
            begin
                r0_next = ra;
                r1_next = rb;
                rcnt_next = 2'd2;
            end
            else if (have_a || have_b)
            begin
                r0_next = have_a ? ra : rb;
                rcnt_next = 2'd1;
            end
        end
    end

    // Result registers.
    always_ff @(posedge clk)
    begin
        r0_reg <= r0_next;
        r1_reg <= r1_next;
    end

    // Cursor and control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rcnt_reg <= '0;
            row_reg <= '0;
            col_reg <= '0;
            srow_reg <= '0;
            scol_reg <= '0;
            prow_reg <= '0;
            pcol_reg <= '0;
            colour_reg <= '0;
            pcolour_reg <= '0;
            gvalid_reg <= 1'b0;
            gwrite_reg <= 1'b0;
            gbytes_reg <= '0;
            glen_reg <= '0;
        end
        else
        begin
            rcnt_reg <= rcnt_next;
            if (go)
            begin
                row_reg <= row_next;
                col_reg <= col_next;
                srow_reg <= srow_next;
                scol_reg <= scol_next;
                prow_reg <= prow_next;
                pcol_reg <= pcol_next;
                colour_reg <= colour_next;
                pcolour_reg <= pcolour_next;
                gvalid_reg <= gvalid_next;
                gwrite_reg <= gwrite_next;
                gbytes_reg <= gbytes_next;
                glen_reg <= glen_next;
            end
        end
    end

endmodule

### src/ansi_terminal_cell_writer_top.sv
// Channel    Dir  Handshake      Payload
// in_ch      in   valid/ready    stream_byte, end_of_frame
// out_ch     out  valid/ready    span write, glyph, colour, last_of_run
// cfg        in   line_width_we  line_width_wdata
// One byte is accepted per cycle while the back end keeps up. The parser classifies a byte
// in the cycle it is accepted and writes it to the queue; the executor takes it from the
// queue, and its results are registered in the output buffer before they are presented.
// A byte that makes two results holds the executor until the first is taken, since the output
// presents one result per cycle to a ready receiver; a stalled receiver holds it while one waits.
// Reset is asynchronous; line_width returns to 120. The two-entry queue lets the parser run ahead.
module ansi_terminal_cell_writer_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        line_width_we,
    input  logic [7:0]  line_width_wdata,
    acw_in_if.sink      in_ch,
    acw_out_if.source   out_ch
);

    logic [7:0]       width_reg;
    logic             f_valid, f_ready, q_valid, q_ready;
    acw_pkg::cmd_t    f_cmd, q_cmd;
    acw_pkg::result_t res;

    // Line width register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= acw_pkg::WIDTH_RESET;
        end
        else if (line_width_we)
        begin
            width_reg <= line_width_wdata;
        end
    end

    acw_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_ready(in_ch.ready),
        .in_byte(in_ch.stream_byte), .in_eof(in_ch.end_of_frame),
        .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
    );

    acw_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_cmd),
        .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_cmd)
    );

    acw_back u_back (
        .clk(clk), .rst_n(rst_n), .line_width(width_reg),
        .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
        .res_valid(out_ch.valid), .res_ready(out_ch.ready), .res(res)
    );

    // Result fields onto the output channel.
    assign out_ch.cell_row = res.cell_row;
    assign out_ch.span_start = res.span_start;
    assign out_ch.span_end = res.span_end;
    assign out_ch.glyph_bytes = res.glyph_bytes;
    assign out_ch.glyph_length = res.glyph_length;
    assign out_ch.colour_active = res.colour_active;
    assign out_ch.colour_first = res.colour_first;
    assign out_ch.colour_second = res.colour_second;
    assign out_ch.last_of_run = res.last_of_run;

endmodule

### src/acw_checker.sv
`include "ansi_terminal_cell_writer_top_macros.svh"
module acw_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [7:0]  span_start,
    input logic [7:0]  span_end,
    input logic [2:0]  glyph_length,
    input logic [31:0] glyph_bytes,
    input logic        colour_active
);

    // A span is never empty.
    `ACW_ASSERT_IMPL(a_span, clk, rst_n, out_valid, span_start < span_end)
    // Glyph length stays within the cap.
    `ACW_ASSERT_IMPL(a_len, clk, rst_n, out_valid, glyph_length <= 3'd4)
    // An erase is blank and uncoloured.
    `ACW_ASSERT_IMPL(a_blank, clk, rst_n, out_valid && glyph_length == 3'd0,
        glyph_bytes == 32'd0 && !colour_active)
    // A stalled result holds its span start.
    `ACW_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(span_start))

endmodule

bind ansi_terminal_cell_writer_top acw_checker u_acw_checker (
    .clk(clk), .rst_n(rst_n),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .span_start(out_ch.span_start), .span_end(out_ch.span_end),
    .glyph_length(out_ch.glyph_length), .glyph_bytes(out_ch.glyph_bytes),
    .colour_active(out_ch.colour_active)
);

### bench/tb_ansi_terminal_cell_writer_top.sv
module tb_ansi_terminal_cell_writer_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 20;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic line_width_we = 1'b0;
    logic [7:0] line_width_wdata = '0;

    acw_in_if in_ch ();
    acw_out_if out_ch ();

    ansi_terminal_cell_writer_top dut (
        .clk(clk),
        .rst_n(rst_n),
        .line_width_we(line_width_we),
        .line_width_wdata(line_width_wdata),
        .in_ch(in_ch),
        .out_ch(out_ch)
    );

    always #5 clk = ~clk;

    // Shadow terminal state.
    logic [7:0]      width_reg;
    acw_pkg::mode_t  sh_mode;
    int unsigned     sh_row, sh_col, sh_srow, sh_scol;
    int unsigned     sh_p[2];
    logic [1:0]      sh_seen;
    int unsigned     sh_slot;
    logic            sh_priv;
    int unsigned     sh_blen;
    logic [32:0]     sh_colour;
    logic            gl_valid, gl_write;
    logic [31:0]     gl_bytes;
    int unsigned     gl_len;
    int unsigned     pl_row, pl_col;
    logic [32:0]     pl_colour;

    acw_pkg::result_t span_queue[$];
    int unsigned new_spans;
    int errors = 0;
    int mismatches = 0;
    int idle_cycles = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    logic timed_out = 1'b0;

    function automatic int unsigned eff_width();
        return (width_reg == 0) ? 1 : width_reg;
    endfunction

    function automatic int unsigned row_plus(int unsigned r, int unsigned n);
        return (r + n > acw_pkg::ROW_LIMIT) ? acw_pkg::ROW_LIMIT : r + n;
    endfunction

    function automatic int unsigned row_minus(int unsigned r, int unsigned n);
        return (n >= r) ? 0 : r - n;
    endfunction

    function automatic int unsigned less_one(int unsigned n);
        return (n == 0) ? 0 : n - 1;
    endfunction

    function automatic int unsigned umin(int unsigned a, int unsigned b);
        return (a < b) ? a : b;
    endfunction

    function automatic void push_span(int unsigned row, int unsigned s, int unsigned e,
                                      logic [31:0] bytes, int unsigned len,
                                      logic [32:0] colour);
        acw_pkg::result_t r;
        r.cell_row = row[9:0];
        r.span_start = s[7:0];
        r.span_end = e[7:0];
        r.glyph_bytes = bytes;
        r.glyph_length = len[2:0];
        r.colour_active = colour[32];
        r.colour_first = colour[15:0];
        r.colour_second = colour[31:16];
        r.last_of_run = 1'b0;
        span_queue.insert(span_queue.size(), r);
        new_spans++;
    endfunction

    function automatic void flush_pending();
        if (gl_valid && gl_write)
            push_span(pl_row, pl_col, pl_col + 1, gl_bytes, gl_len, pl_colour);
        gl_valid = 0;
        gl_write = 0;
        gl_bytes = '0;
        gl_len = 0;
    endfunction

    function automatic void clear_terminal();
        sh_mode = acw_pkg::MODE_GROUND;
        sh_row = 0; sh_col = 0; sh_srow = 0; sh_scol = 0;
        sh_p[0] = 0; sh_p[1] = 0;
        sh_seen = '0; sh_slot = 0; sh_priv = 0; sh_blen = 0;
        sh_colour = '0;
        gl_valid = 0; gl_write = 0; gl_bytes = '0; gl_len = 0;
        pl_row = 0; pl_col = 0; pl_colour = '0;
    endfunction

    function automatic void run_csi(logic [7:0] fb);
        int unsigned w, n1, n2, s, e;
        w = eff_width();
        n1 = sh_seen[0] ? sh_p[0] : 1;
        n2 = sh_seen[1] ? sh_p[1] : 1;
        if (fb == acw_pkg::FB_LM) begin
            if (sh_blen == 0 || (sh_blen == 1 && sh_seen[0] && sh_p[0] == 0))
                sh_colour = '0;
            else
                sh_colour = {1'b1, sh_p[1][15:0], sh_p[0][15:0]};
            return;
        end
        if (sh_priv)
            return;
        case (fb)
            acw_pkg::FB_A: sh_row = row_minus(sh_row, n1);
            acw_pkg::FB_B: sh_row = row_plus(sh_row, n1);
            acw_pkg::FB_C: sh_col = umin(w - 1, sh_col + n1);
            acw_pkg::FB_D: sh_col = (n1 >= sh_col) ? 0 : sh_col - n1;
            acw_pkg::FB_E: begin sh_row = row_plus(sh_row, n1); sh_col = 0; end
            acw_pkg::FB_F: begin sh_row = row_minus(sh_row, n1); sh_col = 0; end
            acw_pkg::FB_G: sh_col = umin(w - 1, less_one(n1));
            acw_pkg::FB_LD: sh_row = umin(acw_pkg::ROW_LIMIT, less_one(n1));
            acw_pkg::FB_H, acw_pkg::FB_LF:
            begin
                sh_row = umin(acw_pkg::ROW_LIMIT, less_one(n1));
                sh_col = umin(w - 1, less_one(n2));
            end
            acw_pkg::FB_LS: begin sh_srow = sh_row; sh_scol = sh_col; end
            acw_pkg::FB_LU: begin sh_row = sh_srow; sh_col = sh_scol; end
            acw_pkg::FB_K:
            begin
                s = sh_col;
                e = w;
                if (sh_seen[0] && sh_p[0] == 1) begin s = 0; e = sh_col + 1; end
                else if (sh_seen[0] && sh_p[0] == 2) begin s = 0; e = w; end
                e = umin(e, w);
                if (s < e)
                    push_span(sh_row, s, e, '0, 0, '0);
            end
            default: ;
        endcase
    endfunction

    // Works out the spans that one stream byte writes.
    function automatic void predict_spans(logic [7:0] b, logic eof);
        int unsigned v, w;
        new_spans = 0;
        if (sh_mode == acw_pkg::MODE_ESC) begin
            if (b == acw_pkg::CH_LBRACKET) begin
                sh_mode = acw_pkg::MODE_CSI;
                sh_p[0] = 0; sh_p[1] = 0;
                sh_seen = '0; sh_slot = 0; sh_priv = 0; sh_blen = 0;
            end
            else
                sh_mode = acw_pkg::MODE_GROUND;
        end
        else if (sh_mode == acw_pkg::MODE_CSI) begin
            if (b >= acw_pkg::FINAL_LO && b <= acw_pkg::FINAL_HI) begin
                sh_mode = acw_pkg::MODE_GROUND;
                run_csi(b);
            end
            else begin
                if (sh_blen < 3)
                    sh_blen++;
                if (b >= acw_pkg::CH_ZERO && b <= acw_pkg::CH_NINE) begin
                    v = sh_p[sh_slot] * 10 + (b - acw_pkg::CH_ZERO);
                    sh_p[sh_slot] = (v > 65535) ? 65535 : v;
                    sh_seen[sh_slot] = 1'b1;
                end
                else if (b == acw_pkg::CH_SEMI)
                    sh_slot = 1;
                else
                    sh_priv = 1;
            end
        end
        else if (gl_valid && (b & acw_pkg::CONT_MASK) == acw_pkg::CONT_CODE) begin
            if (gl_len < acw_pkg::GLYPH_MAX_BYTES) begin
                gl_bytes[8*gl_len +: 8] = b;
                gl_len++;
            end
        end
        else begin
            flush_pending();
            if (b == acw_pkg::CH_ESC)
                sh_mode = acw_pkg::MODE_ESC;
            else if (b == acw_pkg::CH_NL) begin
                sh_row = row_plus(sh_row, 1);
                sh_col = 0;
            end
            else if (b == acw_pkg::CH_CR)
                sh_col = 0;
            else if (b >= acw_pkg::CH_SPACE) begin
                w = eff_width();
                gl_valid = 1;
                gl_write = sh_col < w;
                gl_bytes = {24'd0, b};
                gl_len = 1;
                pl_row = sh_row; pl_col = sh_col; pl_colour = sh_colour;
                sh_col++;
                if (sh_col >= w) begin
                    sh_col = 0;
                    sh_row = row_plus(sh_row, 1);
                end
            end
        end
        if (eof) begin
            flush_pending();
            clear_terminal();
        end
        if (new_spans > 0)
            span_queue[$].last_of_run = 1'b1;
    endfunction

    // Sends one byte and books the spans it should write.
    task automatic send_byte(logic [7:0] b, logic eof = 1'b0);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.stream_byte <= b;
        in_ch.end_of_frame <= eof;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        predict_spans(b, eof);
    endtask

    task automatic send_text(string s, logic eof = 1'b0);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], eof && (i == s.len() - 1));
    endtask

    // Waits until every booked span has arrived, then lets the pipe settle.
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (span_queue.size() != 0 && !timed_out)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_width(logic [7:0] w);
        drain();
        line_width_we <= 1'b1;
        line_width_wdata <= w;
        @(posedge clk);
        line_width_we <= 1'b0;
        width_reg = w;
    endtask

    // Receiver readiness.
    always @(posedge clk) begin
        out_ch.ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    end

    // Compares each written span with the oldest booked one.
    always @(posedge clk) begin
        acw_pkg::result_t got, want;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            got.cell_row = out_ch.cell_row;
            got.span_start = out_ch.span_start;
            got.span_end = out_ch.span_end;
            got.glyph_bytes = out_ch.glyph_bytes;
            got.glyph_length = out_ch.glyph_length;
            got.colour_active = out_ch.colour_active;
            got.colour_first = out_ch.colour_first;
            got.colour_second = out_ch.colour_second;
            got.last_of_run = out_ch.last_of_run;
            if (span_queue.size() == 0) begin
                errors++;
                if (mismatches++ < 10)
                    $display("unexpected span write %p", got);
            end
            else begin
                want = span_queue.pop_front();
                if (got !== want) begin
                    errors++;
                    if (mismatches++ < 10)
                        $display("span mismatch: expected %p actual %p", want, got);
                end
            end
        end
    end

    // Watchdog on cycles with no item moving.
    always @(posedge clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic test_glyphs_and_wrap();
        send_text("Hi");
        send_byte(8'hc3); send_byte(8'ha9);
        send_byte(8'hf0); send_byte(8'h9f); send_byte(8'h98); send_byte(8'h80);
        send_byte(8'hbf); send_byte(8'h80);
        send_byte(8'hff);
        send_text("ab\rc\nd\x01");
        send_text("xyz", 1'b1);
    endtask

    task automatic test_csi_moves();
        send_text("\x1b[5;7H*\x1b[2A*\x1b[3B*\x1b[4C*\x1b[2D*\x1b[E*\x1b[F*");
        send_text("\x1b[9G*\x1b[4d*\x1b[0;0f*\x1b[s\x1b[9;9H*\x1b[u*");
        send_text("\x1b[99999999A*\x1b[2000B*\x1b[3000E*\x1b[1;2;3H*");
        send_text("\x1b[?5H*\x1b[1z*\x1bQ*\x1b[", 1'b1);
    endtask

    task automatic test_colour_and_erase();
        send_text("\x1b[31mR\x1b[1;32;45mG\x1b[0mN\x1b[00mM\x1b[mX\x1b[?7mP");
        send_text("\x1b[65535;65535mQ\x1b[5;1H\x1b[K\x1b[1K\x1b[2K\x1b[0K");
        send_text("\x1b[5G\x1b[K\x1b[3K", 1'b1);
    endtask

    task automatic random_frame(int n);
        int k;
        logic [7:0] b;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(99);
            if (k < 35)
                send_byte(8'($urandom_range(8'h20, 8'h7e)));
            else if (k < 45) begin
                send_byte(8'($urandom_range(8'hc0, 8'hff)));
                repeat ($urandom_range(0, 5)) send_byte(8'($urandom_range(8'h80, 8'hbf)));
            end
            else if (k < 80) begin
                send_byte(acw_pkg::CH_ESC);
                send_byte(($urandom_range(9) == 0) ? 8'($urandom) : acw_pkg::CH_LBRACKET);
                repeat ($urandom_range(0, 7)) begin
                    case ($urandom_range(9))
                        0: b = acw_pkg::CH_SEMI;
                        1: b = 8'($urandom_range(8'h00, 8'h3f));
                        default: b = 8'($urandom_range(acw_pkg::CH_ZERO, acw_pkg::CH_NINE));
                    endcase
                    send_byte(b);
                end
                case ($urandom_range(3))
                    0: send_byte(acw_pkg::FB_K);
                    1: send_byte(acw_pkg::FB_LM);
                    2: send_byte(8'($urandom_range(acw_pkg::FB_A, acw_pkg::FB_H)));
                    default:
                        send_byte(8'($urandom_range(acw_pkg::FINAL_LO, acw_pkg::FINAL_HI)));
                endcase
            end
            else if (k < 90)
                send_byte(8'($urandom_range(0, 31)));
            else
                send_byte(8'($urandom));
        end
        send_byte(8'($urandom), 1'b1);
    endtask

    task automatic test_random_phases();
        int send_pct[4] = '{0, 82, 0, 21};
        int recv_pct[4] = '{0, 0, 82, 21};
        logic [7:0] widths[4] = '{8'd255, 8'd1, 8'd0, 8'd7};
        for (int p = 0; p < 4; p++) begin
            write_width(widths[p]);
            send_idle_pct = send_pct[p];
            recv_stall_pct = recv_pct[p];
            repeat (4) random_frame(11);
            write_width(8'($urandom_range(2, 40)));
            repeat (4) random_frame(11);
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    initial begin
        in_ch.valid = 1'b0;
        in_ch.stream_byte = '0;
        in_ch.end_of_frame = 1'b0;
        out_ch.ready = 1'b0;
        width_reg = acw_pkg::WIDTH_RESET;
        clear_terminal();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_glyphs_and_wrap();
        write_width(8'd3);
        test_csi_moves();
        test_colour_and_erase();
        test_random_phases();
        drain();
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

### ansi_terminal_cell_writer_top.f
+incdir+src
src/acw_pkg.sv
src/acw_in_if.sv
src/acw_out_if.sv
src/acw_front.sv
src/acw_queue.sv
src/acw_back.sv
src/ansi_terminal_cell_writer_top.sv
src/acw_checker.sv
bench/tb_ansi_terminal_cell_writer_top.sv
